@@ hdl/skphd_pkg.sv @@
package skphd_pkg;

    localparam int KEY_COUNT    = 6;
    localparam int MASK_WIDTH   = 8;
    localparam int THR_WIDTH    = 32;
    localparam int STATUS_WIDTH = 2;
    localparam int CFG_IDX_WIDTH = 3;

    typedef enum logic [1:0]
    {
        PHASE_OFF      = 2'd0,
        PHASE_PRESSED  = 2'd1,
        PHASE_HELD     = 2'd2,
        PHASE_RELEASED = 2'd3
    } key_phase_t;

    typedef enum logic [CFG_IDX_WIDTH-1:0]
    {
        CFG_UP_MASK    = 3'd0,
        CFG_DOWN_MASK  = 3'd1,
        CFG_LEFT_MASK  = 3'd2,
        CFG_RIGHT_MASK = 3'd3,
        CFG_OK_MASK    = 3'd4,
        CFG_BACK_MASK  = 3'd5,
        CFG_HOLD_THR   = 3'd6,
        CFG_REL_THR    = 3'd7
    } cfg_index_t;

    typedef struct packed
    {
        logic [KEY_COUNT-1:0][MASK_WIDTH-1:0] key_mask;
        logic [THR_WIDTH-1:0]                 hold_thr;
        logic [THR_WIDTH-1:0]                 rel_thr;
    } cfg_t;

endpackage

@@ hdl/skphd_cfg_regs.sv @@
module skphd_cfg_regs
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic [skphd_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [skphd_pkg::THR_WIDTH-1:0]      cfg_data,
    output skphd_pkg::cfg_t                      cfg
);

    skphd_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < skphd_pkg::KEY_COUNT; k++)
            begin
                cfg_reg.key_mask[k] <= skphd_pkg::MASK_WIDTH'(1 << k);
            end
            cfg_reg.hold_thr <= skphd_pkg::THR_WIDTH'(500);
            cfg_reg.rel_thr  <= skphd_pkg::THR_WIDTH'(20);
        end
        else if (cfg_valid)
        begin
            case (skphd_pkg::cfg_index_t'(cfg_index))
                skphd_pkg::CFG_UP_MASK:
                    cfg_reg.key_mask[0] <= cfg_data[skphd_pkg::MASK_WIDTH-1:0];
                skphd_pkg::CFG_DOWN_MASK:
                    cfg_reg.key_mask[1] <= cfg_data[skphd_pkg::MASK_WIDTH-1:0];
                skphd_pkg::CFG_LEFT_MASK:
                    cfg_reg.key_mask[2] <= cfg_data[skphd_pkg::MASK_WIDTH-1:0];
                skphd_pkg::CFG_RIGHT_MASK:
                    cfg_reg.key_mask[3] <= cfg_data[skphd_pkg::MASK_WIDTH-1:0];
                skphd_pkg::CFG_OK_MASK:
                    cfg_reg.key_mask[4] <= cfg_data[skphd_pkg::MASK_WIDTH-1:0];
                skphd_pkg::CFG_BACK_MASK:
                    cfg_reg.key_mask[5] <= cfg_data[skphd_pkg::MASK_WIDTH-1:0];
                skphd_pkg::CFG_HOLD_THR:
                    cfg_reg.hold_thr <= cfg_data;
                skphd_pkg::CFG_REL_THR:
                    cfg_reg.rel_thr <= cfg_data;
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hdl/skphd_key_fsm.sv @@
module skphd_key_fsm
#(
    parameter int TICK_WIDTH = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step,
    input  logic [skphd_pkg::MASK_WIDTH-1:0]    port_sample,
    input  logic [TICK_WIDTH-1:0]               tick_now,
    input  logic [skphd_pkg::MASK_WIDTH-1:0]    key_mask,
    input  logic [skphd_pkg::THR_WIDTH-1:0]     hold_thr,
    input  logic [skphd_pkg::THR_WIDTH-1:0]     rel_thr,
    output skphd_pkg::key_phase_t               phase
);

    skphd_pkg::key_phase_t phase_reg;
    skphd_pkg::key_phase_t phase_next;
    logic [TICK_WIDTH-1:0] mark_reg;
    logic [TICK_WIDTH-1:0] mark_next;
    logic [TICK_WIDTH-1:0] thr;
    logic [TICK_WIDTH-1:0] limit;
    logic                  key_down;

    assign key_down = ((port_sample & key_mask) == '0);
    // one adder serves both timed phases; the sum wraps at the tick width
    assign thr   = (phase_reg == skphd_pkg::PHASE_PRESSED) ? TICK_WIDTH'(hold_thr)
                                                           : TICK_WIDTH'(rel_thr);
    assign limit = mark_reg + thr;

    always_comb
    begin
        phase_next = phase_reg;
        mark_next  = mark_reg;
        case (phase_reg)
            skphd_pkg::PHASE_OFF:
            begin
                phase_next = key_down ? skphd_pkg::PHASE_PRESSED : skphd_pkg::PHASE_OFF;
                mark_next  = tick_now;
            end
            skphd_pkg::PHASE_PRESSED:
            begin
                if (!key_down)
                begin
                    phase_next = skphd_pkg::PHASE_RELEASED;
                end
                else if (tick_now > limit)
                begin
                    phase_next = skphd_pkg::PHASE_HELD;
                end
            end
            skphd_pkg::PHASE_HELD:
            begin
                phase_next = key_down ? skphd_pkg::PHASE_HELD : skphd_pkg::PHASE_RELEASED;
                mark_next  = tick_now;
            end
            skphd_pkg::PHASE_RELEASED:
            begin
                if (key_down)
                begin
                    phase_next = skphd_pkg::PHASE_PRESSED;
                    mark_next  = tick_now;
                end
                else if (tick_now > limit)
                begin
                    phase_next = skphd_pkg::PHASE_OFF;
                end
            end
            default:
            begin
                phase_next = skphd_pkg::PHASE_OFF;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= skphd_pkg::PHASE_OFF;
            mark_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            mark_reg  <= mark_next;
        end
    end

    assign phase = phase_reg;

endmodule

@@ hdl/six_key_press_hold_debouncer.sv @@
// Six-key press/hold debouncer.
// Slave stream s_*: one word per port sample, tdata = port_sample (8 bits,
// active low) then tick_now (TICK_WIDTH bits). Master stream m_*: one word
// per sample with the six key states (2 bits each: off, pressed, held,
// released) for up, down, left, right, ok, back, lowest bits first.
// Config channel cfg_*: index 0..5 key masks, 6 hold threshold, 7 release
// threshold; cfg_ready is always high, write only while the block is idle.
// A sample lands in an input register; when the result word can advance, six
// key machines (mask test, one add and compare each) update their phase
// registers, and those registers are the result word. Throughput is one word
// per cycle while m_tready keeps the result word moving.
// When m_tready is low the result word holds and one more sample is taken
// into the input register; after that s_tready drops until the word leaves.
// Reset clears both valid flags, sets all keys to off with zero mark times
// and loads the default masks and thresholds.
module six_key_press_hold_debouncer
#(
    parameter int TICK_WIDTH = 32
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // port_sample[7:0], tick_now[TICK_WIDTH+7:8], zero pad to bytes
    input  logic [((skphd_pkg::MASK_WIDTH+TICK_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // up, down, left, right, ok, back status, 2 bits each, then 4 pad bits
    output logic [15:0]                          m_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [skphd_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [skphd_pkg::THR_WIDTH-1:0]      cfg_data
);

    localparam int OUT_BITS = skphd_pkg::KEY_COUNT * skphd_pkg::STATUS_WIDTH;

    skphd_pkg::cfg_t                          cfg;
    logic                                     in_valid_reg;
    logic [skphd_pkg::MASK_WIDTH-1:0]         port_reg;
    logic [TICK_WIDTH-1:0]                    tick_reg;
    logic                                     out_valid_reg;
    logic                                     advance;
    logic                                     step;
    skphd_pkg::key_phase_t                    phase [skphd_pkg::KEY_COUNT];

    assign cfg_ready = 1'b1;

    skphd_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            port_reg <= s_tdata[skphd_pkg::MASK_WIDTH-1:0];
            tick_reg <= s_tdata[skphd_pkg::MASK_WIDTH +: TICK_WIDTH];
        end
    end

    for (genvar k = 0; k < skphd_pkg::KEY_COUNT; k++)
    begin : g_key
        skphd_key_fsm #(.TICK_WIDTH(TICK_WIDTH)) u_key
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .step        (step),
            .port_sample (port_reg),
            .tick_now    (tick_reg),
            .key_mask    (cfg.key_mask[k]),
            .hold_thr    (cfg.hold_thr),
            .rel_thr     (cfg.rel_thr),
            .phase       (phase[k])
        );

        assign m_tdata[k*skphd_pkg::STATUS_WIDTH +: skphd_pkg::STATUS_WIDTH] = phase[k];
    end

    assign m_tdata[15:OUT_BITS] = '0;
    assign m_tvalid = out_valid_reg;

`ifndef NO_ASSERTIONS
    // input side only stalls when the result word is stuck
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("s_tready low without a stalled result word");

    // the up key, once released, never jumps straight to held
    a_rel_not_held: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tdata[1:0] == 2'(skphd_pkg::PHASE_RELEASED)) |=>
        (m_tdata[1:0] != 2'(skphd_pkg::PHASE_HELD)))
        else $error("up key went from released to held");

    // the back key, when idle, must pass through pressed first
    a_off_not_held: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tdata[11:10] == 2'(skphd_pkg::PHASE_OFF)) |=>
        (m_tdata[11:10] != 2'(skphd_pkg::PHASE_HELD)))
        else $error("back key went from off to held");
`endif

endmodule
